@@ hw/rtl/qpe_pkg.sv @@
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, character codes and encode helpers for the quoted-printable
// encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

  // Configuration port geometry
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register word index (paddr[2]); everything else is out of range
  localparam logic REG_LINE_LIMIT = 1'b0;

  localparam logic [7:0] LIMIT_RESET = 8'd76;

  // Character codes
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_EQ  = 8'h3D;
  localparam logic [7:0] PRINT_LO = 8'd33;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // Up to six output characters from one encoded byte
  typedef struct packed {
    logic [5:0][7:0] chars;
    logic [2:0]      count;
  } qpe_seg_t;

  typedef struct packed {
    qpe_seg_t   seg;
    logic [7:0] len;
  } qpe_enc_t;

  // Everything one input request produces, handed to the serializer
  typedef struct packed {
    qpe_seg_t seg_a;
    qpe_seg_t seg_b;
    logic     item_last;
    logic     has_out;
  } qpe_step_t;

  typedef struct packed {
    logic       pending_valid;
    logic [7:0] line_length;
  } qpe_status_t;

  // Upper-case hex digit
  function automatic logic [7:0] qpe_hex(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

  // Encode one byte given the following byte and the current line length
  function automatic qpe_enc_t qpe_encode(input logic [7:0] c, input logic has_next,
                                          input logic [7:0] nxt, input logic [7:0] len,
                                          input logic [7:0] lim);
    logic [7:0] lit_thr;
    logic [7:0] enc_thr;
    logic       literal;
    logic [7:0] base;
    logic [8:0] sum;
    qpe_enc_t   r;
    lit_thr = (lim >= 8'd1) ? lim - 8'd1 : 8'd0;
    enc_thr = (lim >= 8'd3) ? lim - 8'd3 : 8'd0;
    literal = (c >= PRINT_LO && c <= PRINT_HI && c != CHAR_EQ) || c == CHAR_TAB ||
              (c == CHAR_SP && has_next && nxt != CHAR_CR && nxt != CHAR_LF);
    r    = '0;
    base = len;
    sum  = 9'd0;
    if (literal) begin
      if (len >= lit_thr) begin
        r.seg.chars[0] = CHAR_EQ;
        r.seg.chars[1] = CHAR_CR;
        r.seg.chars[2] = CHAR_LF;
        r.seg.chars[3] = c;
        r.seg.count    = 3'd4;
        base           = 8'd0;
      end else begin
        r.seg.chars[0] = c;
        r.seg.count    = 3'd1;
      end
      sum = {1'b0, base} + 9'd1;
    end else if (c == CHAR_LF) begin
      r.seg.chars[0] = CHAR_CR;
      r.seg.chars[1] = CHAR_LF;
      r.seg.count    = 3'd2;
    end else begin
      if (len >= enc_thr) begin
        r.seg.chars[0] = CHAR_EQ;
        r.seg.chars[1] = CHAR_CR;
        r.seg.chars[2] = CHAR_LF;
        r.seg.chars[3] = CHAR_EQ;
        r.seg.chars[4] = qpe_hex(c[7:4]);
        r.seg.chars[5] = qpe_hex(c[3:0]);
        r.seg.count    = 3'd6;
        base           = 8'd0;
      end else begin
        r.seg.chars[0] = CHAR_EQ;
        r.seg.chars[1] = qpe_hex(c[7:4]);
        r.seg.chars[2] = qpe_hex(c[3:0]);
        r.seg.count    = 3'd3;
      end
      sum = {1'b0, base} + 9'd3;
    end
    // Saturate at the limit; a hard line break leaves len at zero
    if (c == CHAR_LF && !literal) begin
      r.len = 8'd0;
    end else if (sum > {1'b0, lim}) begin
      r.len = lim;
    end else begin
      r.len = sum[7:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/qpe_core.sv @@
// ----------------------------------------------------------------------------
// qpe_core
// Look-ahead state (held-back byte, line length) and the encode logic that
// turns one input request into up to two output segments.
// ----------------------------------------------------------------------------
module qpe_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                is_last,
  input  logic [7:0]          line_limit,
  output qpe_pkg::qpe_step_t  step,
  output qpe_pkg::qpe_status_t status
);
  import qpe_pkg::*;

  logic [7:0] pending_byte, pending_byte_next;
  logic       pending_valid, pending_valid_next;
  logic [7:0] line_length, line_length_next;

  qpe_enc_t   enc_pend;
  qpe_enc_t   enc_data;
  logic [7:0] mid_len;

  // Encode the held-back byte, then the incoming one when it ends the message
  always_comb begin
    enc_pend = qpe_encode(pending_byte, 1'b1, data_byte, line_length, line_limit);
    mid_len  = pending_valid ? enc_pend.len : line_length;
    enc_data = qpe_encode(data_byte, 1'b0, 8'd0, mid_len, line_limit);

    step               = '0;
    step.item_last     = is_last;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    line_length_next   = line_length;

    if (pending_valid && pending_byte == CHAR_CR && data_byte == CHAR_LF) begin
      // CR LF pair: hard line break
      step.seg_a.chars[0] = CHAR_CR;
      step.seg_a.chars[1] = CHAR_LF;
      step.seg_a.count    = 3'd2;
      step.has_out        = 1'b1;
      pending_valid_next  = 1'b0;
      pending_byte_next   = 8'd0;
      line_length_next    = 8'd0;
    end else if (pending_valid) begin
      step.seg_a       = enc_pend.seg;
      step.has_out     = 1'b1;
      line_length_next = enc_pend.len;
      if (is_last) begin
        step.seg_b = enc_data.seg;
      end else begin
        pending_byte_next = data_byte;
      end
    end else if (is_last) begin
      step.seg_a   = enc_data.seg;
      step.has_out = 1'b1;
    end else begin
      // First byte of a pair: only held back
      pending_byte_next  = data_byte;
      pending_valid_next = 1'b1;
    end

    if (is_last) begin
      pending_byte_next  = 8'd0;
      pending_valid_next = 1'b0;
      line_length_next   = 8'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte  <= 8'd0;
      pending_valid <= 1'b0;
      line_length   <= 8'd0;
    end else if (accept) begin
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
      line_length   <= line_length_next;
    end
  end

  assign status.pending_valid = pending_valid;
  assign status.line_length   = line_length;

endmodule

@@ hw/rtl/qpe_serializer.sv @@
// ----------------------------------------------------------------------------
// qpe_serializer
// Result register for one request's segments; sends one character per cycle
// while out_ready is high, taking the next request as the final one leaves.
// ----------------------------------------------------------------------------
module qpe_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  qpe_pkg::qpe_step_t step,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               message_end
);
  import qpe_pkg::*;

  qpe_step_t  hold;
  logic       busy;
  logic       phase;
  logic [2:0] idx;

  logic       seg_end;
  logic       fire;

  always_comb begin
    fire     = busy && out_ready;
    seg_end  = phase ? (idx == hold.seg_b.count - 3'd1) : (idx == hold.seg_a.count - 3'd1);
    run_last = seg_end && (phase || hold.seg_b.count == 3'd0);
    out_byte = phase ? hold.seg_b.chars[idx] : hold.seg_a.chars[idx];
    can_load = !busy || (fire && run_last);
  end

  assign out_valid   = busy;
  assign message_end = run_last && hold.item_last;

  // Payload register
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      hold <= step;
    end
  end

  // Read position and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      idx   <= 3'd0;
    end else if (load && can_load) begin
      busy  <= 1'b1;
      phase <= 1'b0;
      idx   <= 3'd0;
    end else if (fire) begin
      if (run_last) begin
        busy <= 1'b0;
      end else if (seg_end) begin
        phase <= 1'b1;
        idx   <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

@@ hw/rtl/quoted_printable_encoder.sv @@
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// Streaming quoted-printable encoder with a programmable line limit.
// ----------------------------------------------------------------------------
// Each input request carries one raw byte; the byte is held back until the
// next one arrives, so a request yields zero to twelve output characters,
// sent one per cycle while m_tready is high. An input request is taken in
// the same cycle the last character of the previous one leaves, so the block
// runs at one character per cycle unless m_tready stalls it. An encoded byte
// gives one character as a literal or three as an escaped byte, and three
// more with a soft break; a request that only stores a held-back byte gives
// none. line_limit (address 0, reset 76)
// may only be changed while no message is in flight. m_tlast marks the final
// character of a message; m_tuser marks the final character of each request.
module quoted_printable_encoder (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qpe_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [qpe_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [qpe_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,   // is_last
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic                            m_tlast,   // message_end
  output logic                            m_tuser    // [0] run_last
);
  import qpe_pkg::*;

  logic [7:0]  line_limit;
  logic        s_fire;
  logic        can_load;
  qpe_step_t   step;
  qpe_status_t status;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_LINE_LIMIT) begin
      line_limit <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_LINE_LIMIT) ?
                  {{(APB_DATA_W-8){1'b0}}, line_limit} : '0;

  // Input handshake
  assign s_tready = can_load;
  assign s_fire   = s_tvalid && s_tready;

  qpe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_fire),
    .data_byte  (s_tdata),
    .is_last    (s_tlast),
    .line_limit (line_limit),
    .step       (step),
    .status     (status)
  );

  qpe_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load        (s_fire && step.has_out),
    .step        (step),
    .can_load    (can_load),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .run_last    (m_tuser),
    .message_end (m_tlast)
  );

  // Assertions
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tlast) |=> (!status.pending_valid && status.line_length == 8'd0))
    else $error("state not cleared after message end");

  a_first_held: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !s_tlast && !status.pending_valid) |=> status.pending_valid)
    else $error("first byte of a pair not held back");

  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("message end without request end");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule
